FILE: hw/rtl/itdc_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
package itdc_pkg;

	localparam int VALUE_BITS = 16;
	localparam int IN_BITS    = 16;
	localparam int NDIG       = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int DIG_IDX_W  = $clog2(NDIG);
	localparam int CNT_W      = $clog2(VALUE_BITS + 1);
	localparam int WR_DATA_W  = 5;
	localparam int CHAR_W     = 8;
	localparam int LEN_W      = 4;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

	typedef enum logic [1:0] {
		REG_SIGNED_MODE = 2'd0,
		REG_BUFFER_SIZE = 2'd1,
		REG_PAD_WIDTH   = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	typedef logic [3:0] digit_t;
	typedef logic [NDIG-1:0][3:0] bcd_t;

	typedef struct packed {
		logic             signed_mode;
		logic [LEN_W-1:0] budget;
		logic [LEN_W-1:0] pad_width;
	} cfg_t;

	typedef struct packed {
		logic                  load;
		logic [VALUE_BITS-1:0] mag;
	} bcd_cmd_t;

	typedef struct packed {
		logic             done;
		logic [LEN_W-1:0] sig_digits;
	} bcd_stat_t;

endpackage

FILE: hw/rtl/itdc_intf.sv
// Request channel interfaces: input words and output characters.
interface itdc_in_if import itdc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [IN_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface itdc_out_if import itdc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              is_last;
	logic [LEN_W-1:0]  number_length;

	modport source (output valid, output character, output is_last, output number_length,
		input ready);
	modport sink   (input valid, input character, input is_last, input number_length,
		output ready);
endinterface

FILE: hw/rtl/itdc_bcd_unit.sv
// Iterative shift-and-add-3 binary to BCD unit, one bit per cycle.
module itdc_bcd_unit import itdc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  bcd_cmd_t  cmd,
	output bcd_stat_t stat,
	output bcd_t      bcd
);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [VALUE_BITS-1:0] bin_q;
	bcd_t                  bcd_q;
	bcd_t                  adj;
	logic [NDIG*4-1:0]     adj_flat;
	bcd_t                  bcd_sh;
	logic [LEN_W-1:0]      sig;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	assign adj_flat = adj;
	assign bcd_sh   = {adj_flat[NDIG*4-2:0], bin_q[VALUE_BITS-1]};

	always_comb begin
		sig = LEN_W'(1);
		for (int i = 1; i < NDIG; i++) begin
			if (bcd_q[i] != 4'd0) begin
				sig = LEN_W'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.load) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(VALUE_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= cmd.mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= bcd_sh;
		end
	end

	assign stat.done       = done_q;
	assign stat.sig_digits = sig;
	assign bcd             = bcd_q;

endmodule

FILE: hw/rtl/itdc_seq.sv
// Sequencer: takes words, runs the BCD unit, sizes the field and emits characters.
module itdc_seq import itdc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	itdc_in_if.sink   value_ch,
	itdc_out_if.source char_ch,
	output bcd_cmd_t  cmd,
	input  bcd_stat_t stat,
	input  bcd_t      bcd
);

	state_t                state_q, state_d;
	logic                  neg_q;
	logic                  sign_q;
	logic [LEN_W-1:0]      len_q;
	logic [LEN_W-1:0]      last_q;
	logic [LEN_W-1:0]      k_q;
	logic [VALUE_BITS-1:0] word;
	logic                  in_acc;
	logic                  out_acc;
	logic [LEN_W-1:0]      ndig_d;
	logic                  sign_d;
	logic [LEN_W-1:0]      len_d;
	logic [LEN_W-1:0]      tot_d;
	logic [LEN_W-1:0]      didx;
	digit_t                dsel;

	assign word    = VALUE_BITS'(value_ch.value);
	assign in_acc  = value_ch.valid & value_ch.ready;
	assign out_acc = char_ch.valid & char_ch.ready;

	// field sizing from the finished conversion
	assign ndig_d = (stat.sig_digits < cfg.budget) ? stat.sig_digits : cfg.budget;
	assign sign_d = neg_q & (ndig_d < cfg.budget);
	assign len_d  = ndig_d + LEN_W'(sign_d);
	assign tot_d  = (len_d > cfg.pad_width) ? len_d : cfg.pad_width;

	assign didx = len_q - LEN_W'(1) - k_q;
	assign dsel = bcd[didx[DIG_IDX_W-1:0]];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (stat.done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_acc && k_q == last_q) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		value_ch.ready        = 1'b0;
		char_ch.valid         = 1'b0;
		cmd.load              = in_acc;
		cmd.mag               = (cfg.signed_mode & word[VALUE_BITS-1]) ? (~word + 1'b1) : word;
		char_ch.is_last       = (k_q == last_q);
		char_ch.number_length = len_q;
		if (sign_q && k_q == '0) begin
			char_ch.character = CHAR_MINUS;
		end else if (k_q < len_q) begin
			char_ch.character = CHAR_ZERO + {4'd0, dsel};
		end else begin
			char_ch.character = CHAR_SPACE;
		end
		unique case (state_q)
			ST_IDLE: value_ch.ready = 1'b1;
			ST_CONV: ;
			ST_EMIT: char_ch.valid  = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CONV && stat.done) begin
				k_q <= '0;
			end else if (out_acc) begin
				k_q <= k_q + LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			neg_q <= cfg.signed_mode & word[VALUE_BITS-1];
		end
		if (state_q == ST_CONV && stat.done) begin
			sign_q <= sign_d;
			len_q  <= len_d;
			last_q <= tot_d - LEN_W'(1);
		end
	end

endmodule

FILE: hw/rtl/integer_to_decimal_ascii_top.sv
// Top level of the binary to decimal ASCII converter.
// Usage:
//   value_ch takes one word per request; in signed mode it is two's
//   complement and a negative word prints with a leading minus if room.
//   char_ch returns the decimal text, most significant character first,
//   one character per request, padded with trailing spaces to pad_width;
//   is_last marks the final character, number_length counts sign+digits.
//   wr_en/wr_index/wr_data write signed_mode, buffer_size, pad_width;
//   write only while idle (value_ch.ready high).
// Timing:
//   A word is converted by a shift-and-add-3 unit, one bit per cycle; the
//   sequencer then sizes the field and offers the first character.
//   Characters then leave one per cycle while char_ch.ready is high;
//   value_ch.ready is low from acceptance until the last character is
//   taken, so a new word is not accepted before then.
// Reset: returns to idle with signed_mode 0, buffer_size 10, pad_width 0.
// Stall: a low char_ch.ready holds the current character and the sequence.
module integer_to_decimal_ascii_top import itdc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	itdc_in_if.sink              value_ch,
	itdc_out_if.source           char_ch,
	input  logic                 wr_en,
	input  logic [1:0]           wr_index,
	input  logic [WR_DATA_W-1:0] wr_data
);

	logic       signed_mode_q;
	logic [4:0] buffer_size_q;
	logic [3:0] pad_width_q;
	cfg_t       cfg;
	bcd_cmd_t   cmd;
	bcd_stat_t  stat;
	bcd_t       bcd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b0;
			buffer_size_q <= 5'd10;
			pad_width_q   <= 4'd0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SIGNED_MODE: signed_mode_q <= wr_data[0];
				REG_BUFFER_SIZE: buffer_size_q <= wr_data[4:0];
				REG_PAD_WIDTH:   pad_width_q   <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.signed_mode = signed_mode_q;
		cfg.pad_width   = pad_width_q;
		if (buffer_size_q < 5'd2) begin
			cfg.budget = 4'd1;
		end else if (buffer_size_q > 5'd16) begin
			cfg.budget = 4'd15;
		end else begin
			cfg.budget = 4'(buffer_size_q - 5'd1);
		end
	end

	itdc_bcd_unit u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.bcd    (bcd)
	);

	itdc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.value_ch (value_ch),
		.char_ch  (char_ch),
		.cmd      (cmd),
		.stat     (stat),
		.bcd      (bcd)
	);

`ifndef NO_ASSERTIONS
	a_idle_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		value_ch.ready |-> !char_ch.valid)
		else $error("character offered while idle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(value_ch.valid && value_ch.ready) |=> !value_ch.ready)
		else $error("new word taken during conversion");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(char_ch.valid && char_ch.ready && char_ch.is_last) |=> value_ch.ready)
		else $error("not idle after last character");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		char_ch.valid |-> (char_ch.number_length != 4'd0))
		else $error("zero number length");
`endif

endmodule

FILE: tb/integer_to_decimal_ascii_top_test.sv
// Testbench for integer_to_decimal_ascii_top: word to decimal text, checked per character.
`timescale 1ns / 1ps

module integer_to_decimal_ascii_top_test;
	import itdc_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = VALUE_BITS + 2 + 15 + 8;
	localparam int RANDOM_ITEMS = 150;
	localparam int PHASES       = 10;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              is_last;
		logic [LEN_W-1:0]  number_length;
	} char_exp_t;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [1:0]           wr_index;
	logic [WR_DATA_W-1:0] wr_data;

	itdc_in_if  value_if ();
	itdc_out_if char_if ();

	integer_to_decimal_ascii_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.value_ch (value_if.sink),
		.char_ch  (char_if.source),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	char_exp_t expected_chars[$];
	char_exp_t want;

	logic                 cfg_signed_mode;
	logic [4:0]           cfg_buffer_size;
	logic [3:0]           cfg_pad_width;

	int  error_count = 0;
	int  cycle_count = 0;
	int  ready_hold  = 0;
	bit  calm        = 0;

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** integer_to_decimal_ascii_top: FAILED **");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		if (error_count < 100)
			$display("%0t ns: mismatch: %s", $time, what);
		error_count++;
	endtask

	// Expected text for one word under the current register settings.
	function automatic void predict_text(input logic [IN_BITS-1:0] raw);
		logic [VALUE_BITS-1:0] word;
		logic [VALUE_BITS-1:0] twos;
		int unsigned           mag;
		logic                  neg;
		int                    size;
		int                    budget;
		int                    len;
		int                    total;
		logic [CHAR_W-1:0]     digits [15];
		char_exp_t             e;

		word = raw[VALUE_BITS-1:0];
		mag  = 32'(word);
		neg  = 1'b0;
		if (cfg_signed_mode && word[VALUE_BITS-1]) begin
			neg  = 1'b1;
			twos = ~word + 1'b1;
			mag  = 32'(twos);
			if (mag == 0 || mag > (1 << (VALUE_BITS - 1)))
				mag = 1 << (VALUE_BITS - 1);
		end
		size = 32'(cfg_buffer_size);
		if (size < 2)
			size = 2;
		if (size > 16)
			size = 16;
		budget = size - 1;
		len = 0;
		while (len < budget) begin
			digits[len] = CHAR_ZERO + CHAR_W'(mag % 10);
			len++;
			mag = mag / 10;
			if (mag == 0)
				break;
		end
		if (neg && len < budget) begin
			digits[len] = CHAR_MINUS;
			len++;
		end
		total = len;
		if (int'(cfg_pad_width) > total)
			total = 32'(cfg_pad_width);
		if (total > 15)
			total = 15;
		for (int k = 0; k < total; k++) begin
			e.character     = (k < len) ? digits[len - 1 - k] : CHAR_SPACE;
			e.is_last       = (k + 1 == total);
			e.number_length = len[LEN_W-1:0];
			expected_chars.push_back(e);
		end
	endfunction

	// Output side: random stall bursts, no new ones once calm is set.
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			char_if.ready <= 1'b0;
			ready_hold    <= ready_hold - 1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			char_if.ready <= 1'b0;
			ready_hold    <= $urandom_range(0, 4);
		end else begin
			char_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && char_if.valid && char_if.ready) begin
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected character 0x%02h", char_if.character));
			end else begin
				want = expected_chars.pop_front();
				if (char_if.character !== want.character)
					report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
						char_if.character, want.character));
				if (char_if.is_last !== want.is_last)
					report_mismatch($sformatf("is_last %b, expected %b",
						char_if.is_last, want.is_last));
				if (char_if.number_length !== want.number_length)
					report_mismatch($sformatf("number_length %0d, expected %0d",
						char_if.number_length, want.number_length));
			end
		end
	end

	task automatic send_word(input logic [IN_BITS-1:0] word);
		if (!calm && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 5)) @(posedge clk);
		value_if.valid <= 1'b1;
		value_if.value <= word;
		do @(posedge clk); while (!value_if.ready);
		predict_text(word);
		value_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		wait (expected_chars.size() == 0);
		@(posedge clk);
		while (!value_if.ready) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [WR_DATA_W-1:0] data);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		case (idx)
			REG_SIGNED_MODE: cfg_signed_mode = data[0];
			REG_BUFFER_SIZE: cfg_buffer_size = data[4:0];
			REG_PAD_WIDTH:   cfg_pad_width   = data[3:0];
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic configure(input logic sgn, input logic [4:0] bsize, input logic [3:0] pad);
		wait_idle();
		write_reg(REG_SIGNED_MODE, WR_DATA_W'(sgn));
		write_reg(REG_BUFFER_SIZE, WR_DATA_W'(bsize));
		write_reg(REG_PAD_WIDTH, WR_DATA_W'(pad));
	endtask

	function automatic logic [IN_BITS-1:0] random_word();
		int unsigned tens [5] = '{1, 10, 100, 1000, 10000};
		case ($urandom_range(0, 4))
			1: return IN_BITS'($urandom_range(0, 99));
			2: return IN_BITS'(tens[$urandom_range(0, 4)] + $urandom_range(0, 2) - 1);
			3: return $urandom_range(0, 1) ? IN_BITS'(16'h8000 + $urandom_range(0, 3))
				: IN_BITS'(16'hFFFF - $urandom_range(0, 3));
			default: return IN_BITS'($urandom);
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_word(16'd0);
		send_word(16'd65535);
		send_word(16'd12345);
		send_word(16'h8000);
	endtask

	task automatic test_unsigned_range();
		configure(1'b0, 5'd16, 4'd0);
		send_word(16'd1);
		send_word(16'd9);
		send_word(16'd10);
		send_word(16'd65535);
		send_word(16'h7FFF);
	endtask

	task automatic test_signed_range();
		configure(1'b1, 5'd16, 4'd0);
		send_word(16'h8000);
		send_word(16'hFFFF);
		send_word(16'h7FFF);
		send_word(16'h8001);
		send_word(16'd0);
	endtask

	task automatic test_short_buffer();
		configure(1'b1, 5'd0, 4'd0);
		send_word(16'd12345);
		configure(1'b1, 5'd1, 4'd0);
		send_word(16'hFF85);
		configure(1'b1, 5'd3, 4'd0);
		send_word(16'hFF85);
		configure(1'b1, 5'd4, 4'd0);
		send_word(16'hFF85);
		configure(1'b1, 5'd5, 4'd0);
		send_word(16'hFF85);
		configure(1'b1, 5'd31, 4'd0);
		send_word(16'h8000);
	endtask

	task automatic test_padding();
		configure(1'b0, 5'd10, 4'd15);
		send_word(16'd7);
		configure(1'b0, 5'd10, 4'd3);
		send_word(16'd12345);
		send_word(16'd5);
		configure(1'b1, 5'd16, 4'd15);
		send_word(16'h8000);
		send_word(16'd0);
	endtask

	task automatic test_random_words();
		int per_phase;
		per_phase = RANDOM_ITEMS / PHASES;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: configure(1'b1, 5'd31, 4'd15);
				1: configure(1'b0, 5'd0, 4'd0);
				2: configure(1'b1, 5'd2, 4'd1);
				default: configure(1'($urandom_range(0, 1)),
					$urandom_range(0, 1) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(4, 16)),
					4'($urandom));
			endcase
			if (ph == PHASES - 1)
				calm = 1;
			for (int i = 0; i < per_phase; i++) begin
				send_word(random_word());
				// hold off until the converter has fully drained
				if (ph == 3)
					wait_idle();
			end
		end
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		wr_en           = 1'b0;
		wr_index        = REG_SIGNED_MODE;
		wr_data         = '0;
		value_if.valid  = 1'b0;
		value_if.value  = '0;
		char_if.ready   = 1'b0;
		cfg_signed_mode = 1'b0;
		cfg_buffer_size = 5'd10;
		cfg_pad_width   = 4'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_unsigned_range();
		test_signed_range();
		test_short_buffer();
		test_padding();
		test_random_words();

		wait (expected_chars.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("** integer_to_decimal_ascii_top: PASSED **");
		end else begin
			$display("** integer_to_decimal_ascii_top: FAILED **");
		end
		$finish;
	end

endmodule
